/* rtl/modular_add_sub_mult_unit_core_defines.svh */
// Assertion macros shared by the modular arithmetic unit.
`ifndef MODULAR_ADD_SUB_MULT_UNIT_CORE_DEFINES_SVH
`define MODULAR_ADD_SUB_MULT_UNIT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MASMU_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular unit check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MASMU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular unit check failed: next-cycle implication");

`endif

/* rtl/masmu_pkg.sv */
// Package with shared types and constants of the modular arithmetic unit.
`timescale 1ns / 1ps

package masmu_pkg;

    localparam int WORD_W     = 32;
    localparam int PROD_W     = 64;
    localparam int MOD_W      = 31;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 4;

    localparam logic [MOD_W-1:0]   MODULUS_RST   = 31'd2013265921;
    localparam logic [WORD_W-1:0]  FACTOR_RST    = 32'd2290649223;
    localparam logic [SHIFT_W-1:0] PRE_SHIFT_RST = 6'd30;
    localparam logic [SHIFT_W-1:0] POST_SHIFT_RST = 6'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PRE_SHIFT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_POST_SHIFT = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_MUL  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Control that travels alongside the data through the pipeline; the last stage keeps only the valid bit, as done.
    typedef struct packed {
        logic valid;
        op_t  op;
    } ctl_t;

endpackage

/* rtl/masmu_front.sv */
// First pipeline stage: full product and raw sum or difference of the operands.
`timescale 1ns / 1ps

module masmu_front
    import masmu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  op_t               in_op,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output ctl_t              ctl,
    output logic [PROD_W-1:0] prod,
    output logic [WORD_W-1:0] raw
);

    ctl_t              ctl_reg;
    ctl_t              ctl_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [WORD_W-1:0] raw_reg;
    logic [WORD_W-1:0] raw_next;

    always_comb
    begin
        ctl_next.valid = in_valid;
        ctl_next.op    = in_op;
        prod_next      = PROD_W'(a) * PROD_W'(b);
        // Sum and difference both wrap at the word width.
        raw_next       = (in_op == OP_SUB) ? (a - b) : (a + b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        raw_reg  <= raw_next;
    end

    assign ctl  = ctl_reg;
    assign prod = prod_reg;
    assign raw  = raw_reg;

endmodule

/* rtl/masmu_barrett.sv */
// Barrett quotient estimate: four stages from the product to the low word of c times p.
`timescale 1ns / 1ps

module masmu_barrett
    import masmu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl_in,
    input  logic [PROD_W-1:0]  prod,
    input  logic [WORD_W-1:0]  raw,
    input  logic [MOD_W-1:0]   modulus,
    input  logic [WORD_W-1:0]  factor,
    input  logic [SHIFT_W-1:0] pre_shift,
    input  logic [SHIFT_W-1:0] post_shift,
    output ctl_t               ctl_out,
    output logic [WORD_W-1:0]  word,
    output logic [WORD_W-1:0]  cp
);

    localparam int NSTG = 4;

    ctl_t              ctl_reg  [NSTG];
    logic [WORD_W-1:0] word_reg [NSTG];

    logic [WORD_W-1:0] t_reg;
    logic [WORD_W-1:0] t_next;
    logic [PROD_W-1:0] tq_reg;
    logic [PROD_W-1:0] tq_next;
    logic [WORD_W-1:0] c_reg;
    logic [WORD_W-1:0] c_next;
    logic [WORD_W-1:0] cp_reg;
    logic [WORD_W-1:0] cp_next;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        // For a multiply the low product word goes on; otherwise the raw sum or difference.
        word_next = (ctl_in.op == OP_MUL) ? prod[WORD_W-1:0] : raw;
        t_next    = WORD_W'(prod >> pre_shift);
        tq_next   = PROD_W'(t_reg) * PROD_W'(factor);
        c_next    = WORD_W'(tq_reg >> post_shift);
        cp_next   = c_reg * WORD_W'(modulus);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < NSTG; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg[0] <= word_next;
        for (int i = 1; i < NSTG; i++)
        begin
            word_reg[i] <= word_reg[i-1];
        end
        t_reg  <= t_next;
        tq_reg <= tq_next;
        c_reg  <= c_next;
        cp_reg <= cp_next;
    end

    assign ctl_out = ctl_reg[NSTG-1];
    assign word    = word_reg[NSTG-1];
    assign cp      = cp_reg;

endmodule

/* rtl/masmu_final.sv */
// Last two stages: Barrett remainder, then the conditional correction by p.
`timescale 1ns / 1ps

module masmu_final
    import masmu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl_in,
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] cp,
    input  logic [MOD_W-1:0]  modulus,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    ctl_t              ctl_reg;
    logic              done_reg;
    logic [WORD_W-1:0] v_reg;
    logic [WORD_W-1:0] v_next;
    logic [WORD_W-1:0] res_reg;
    logic [WORD_W-1:0] res_next;
    logic [WORD_W-1:0] cand;

    always_comb
    begin
        v_next = (ctl_in.op == OP_MUL) ? (word - cp) : word;
    end

    always_comb
    begin
        cand     = '0;
        res_next = '0;
        case (ctl_reg.op)
            OP_ADD, OP_MUL:
            begin
                cand     = v_reg - WORD_W'(modulus);
                res_next = (cand < v_reg) ? cand : v_reg;
            end
            OP_SUB:
            begin
                cand     = v_reg + WORD_W'(modulus);
                res_next = (cand < v_reg) ? cand : v_reg;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            done_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/modular_add_sub_mult_unit_core.sv */
// Top level of the modular add, subtract and Barrett multiply unit.
`timescale 1ns / 1ps

`include "modular_add_sub_mult_unit_core_defines.svh"

// Modular arithmetic unit. A request is taken on every clock edge where start
// is high; busy never rises, so one request per cycle is sustained. Each
// request returns exactly one mod_result, marked by done, in request order.
// The pipeline depth is set by the multiply path: operand product, pre-shift,
// multiply by the Barrett factor, post-shift, multiply by the modulus,
// remainder, and the final correction each own one register stage. Add and
// subtract ride the same pipeline so results never reorder. The receiver
// cannot stall, and none is needed since done fires for one cycle per
// request. Configuration writes are always ready and take effect at once;
// change them only while no request is in flight. Writes to indexes above
// three are ignored.
module modular_add_sub_mult_unit_core
    import masmu_pkg::*;
#(
    parameter int CfgIdxWidth = CFG_IDX_W
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             req_type,
    input  logic [WORD_W-1:0]      operand_a,
    input  logic [WORD_W-1:0]      operand_b,
    output logic                   done,
    output logic [WORD_W-1:0]      mod_result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    logic [MOD_W-1:0]   modulus_reg;
    logic [WORD_W-1:0]  factor_reg;
    logic [SHIFT_W-1:0] pre_shift_reg;
    logic [SHIFT_W-1:0] post_shift_reg;
    logic               cfg_wr;

    ctl_t               front_ctl;
    logic [PROD_W-1:0]  front_prod;
    logic [WORD_W-1:0]  front_raw;
    ctl_t               bar_ctl;
    logic [WORD_W-1:0]  bar_word;
    logic [WORD_W-1:0]  bar_cp;
    logic               accept;

    // The pipeline never stalls, so both request channels are always open.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= MODULUS_RST;
            factor_reg     <= FACTOR_RST;
            pre_shift_reg  <= PRE_SHIFT_RST;
            post_shift_reg <= POST_SHIFT_RST;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == CfgIdxWidth'(REG_MODULUS))
            begin
                modulus_reg <= cfg_data[MOD_W-1:0];
            end
            if (cfg_index == CfgIdxWidth'(REG_FACTOR))
            begin
                factor_reg <= cfg_data;
            end
            if (cfg_index == CfgIdxWidth'(REG_PRE_SHIFT))
            begin
                pre_shift_reg <= cfg_data[SHIFT_W-1:0];
            end
            if (cfg_index == CfgIdxWidth'(REG_POST_SHIFT))
            begin
                post_shift_reg <= cfg_data[SHIFT_W-1:0];
            end
        end
    end

    masmu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_op    (op_t'(req_type)),
        .a        (operand_a),
        .b        (operand_b),
        .ctl      (front_ctl),
        .prod     (front_prod),
        .raw      (front_raw)
    );

    masmu_barrett u_barrett (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (front_ctl),
        .prod       (front_prod),
        .raw        (front_raw),
        .modulus    (modulus_reg),
        .factor     (factor_reg),
        .pre_shift  (pre_shift_reg),
        .post_shift (post_shift_reg),
        .ctl_out    (bar_ctl),
        .word       (bar_word),
        .cp         (bar_cp)
    );

    masmu_final u_final (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (bar_ctl),
        .word    (bar_word),
        .cp      (bar_cp),
        .modulus (modulus_reg),
        .done    (done),
        .result  (mod_result)
    );

    // A taken request enters the first stage on the next cycle.
    `MASMU_ASSERT_NEXT(a_enter_pipe, accept, front_ctl.valid)
    // Every result traces back to an earlier taken request.
    `MASMU_ASSERT_IMPLIES(a_done_has_request, done, $past(accept, 7))
    // The unused operation code always yields zero.
    `MASMU_ASSERT_IMPLIES(a_unused_op_zero,
        done && ($past(req_type, 7) == OP_NONE), mod_result == '0)

endmodule
